@@ rtl/ctbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbs_pkg
// Types and constants shared by the CAN transmit buffer scheduler modules.
// ----------------------------------------------------------------------------
package ctbs_pkg;

	localparam int TX_BUFFERS  = 32;
	localparam int IDX_W       = (TX_BUFFERS > 1) ? $clog2(TX_BUFFERS) : 1;
	localparam int CNT_W       = $clog2(TX_BUFFERS + 1);
	localparam int CFG_W       = 6;
	localparam int BUF_INDEX_W = 5;
	localparam int PEND_W      = 16;
	localparam int MARK_W      = 2;
	localparam int APB_ADDR_W  = 3;
	localparam logic [PEND_W-1:0] PEND_MAX = '1;
	localparam logic [CFG_W-1:0]  BUFFERS_IN_USE_RST = CFG_W'(32);

	typedef enum logic [1:0] {
		OP_INIT     = 2'd0,
		OP_SEND     = 2'd1,
		OP_TX_DONE  = 2'd2,
		OP_CLR_SYNC = 2'd3
	} ctbs_op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_ILLEGAL  = 2'd2
	} ctbs_status_t;

	typedef enum logic [1:0] {
		DROP_NONE    = 2'd0,
		DROP_INHIBIT = 2'd1,
		DROP_QUEUED  = 2'd2
	} ctbs_drop_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SEND,
		S_SCAN,
		S_FINISH
	} ctbs_state_t;

	typedef struct packed {
		ctbs_op_t                operation;
		logic [BUF_INDEX_W-1:0]  buffer_index;
		logic                    sync_flag;
		logic                    mailbox_free;
	} ctbs_item_t;

	typedef struct packed {
		ctbs_drop_t              sync_dropped;
		logic [BUF_INDEX_W-1:0]  transmit_index;
		logic                    transmit_valid;
		logic                    overflow_report;
		ctbs_status_t            status;
	} ctbs_result_t;

	typedef struct packed {
		logic sync;
		logic full;
	} ctbs_mark_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		ctbs_mark_t       wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ctbs_mem_req_t;

endpackage

@@ rtl/can_tx_buffer_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_tx_buffer_scheduler
// Schedules CAN transmit buffers over a mark RAM with an APB register port.
// ----------------------------------------------------------------------------
// Flow: one item is in work at a time; a new item is taken only after the
// result of the last has left for the output register. Transmit complete and
// clear-sync scan the marks of the buffers in use through the mark RAM, which
// reads one entry per cycle through its single read port.
// Reset: marks read as zero through per-entry valid bits, counter and inhibit
// clear, boot set, buffers_in_use 32; no clearing pass is needed.
module can_tx_buffer_scheduler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// buffer_index, sync_flag, mailbox_free, zero pad
	input  logic [7:0]                        s_tdata,
	// operation
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status, overflow_report, transmit_valid, transmit_index, sync_dropped, zero pad
	output logic [15:0]                       m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ctbs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	logic [ctbs_pkg::CFG_W-1:0]   buf_use_q;
	logic [ctbs_pkg::CNT_W-1:0]   count_in_use;
	ctbs_pkg::ctbs_item_t         item;
	ctbs_pkg::ctbs_result_t       res;
	ctbs_pkg::ctbs_result_t       out_q;
	logic                         out_vld_q;
	logic                         res_valid;
	logic                         res_ready;
	ctbs_pkg::ctbs_mem_req_t      mem_req;
	logic [ctbs_pkg::MARK_W-1:0]  mem_rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(buf_use_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_use_q <= ctbs_pkg::BUFFERS_IN_USE_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			buf_use_q <= pwdata[ctbs_pkg::CFG_W-1:0];
		end
	end

	always_comb begin
		if (32'(buf_use_q) > ctbs_pkg::TX_BUFFERS) begin
			count_in_use = ctbs_pkg::CNT_W'(ctbs_pkg::TX_BUFFERS);
		end else begin
			count_in_use = ctbs_pkg::CNT_W'(buf_use_q);
		end
	end

	assign item.operation    = ctbs_pkg::ctbs_op_t'(s_tuser);
	assign item.buffer_index = s_tdata[4:0];
	assign item.sync_flag    = s_tdata[5];
	assign item.mailbox_free = s_tdata[6];

	ctbs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (s_tvalid),
		.item_ready   (s_tready),
		.item         (item),
		.count_in_use (count_in_use),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.mem_req      (mem_req),
		.mem_rdata    (ctbs_pkg::ctbs_mark_t'(mem_rdata))
	);

	ctbs_mark_ram #(
		.DEPTH (ctbs_pkg::TX_BUFFERS),
		.WIDTH (ctbs_pkg::MARK_W)
	) u_mark_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, out_q};

	a_index_zero_when_idle : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[8:4] == 5'd0)
		else $error("transmit index set without a transmission");

	a_illegal_is_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == ctbs_pkg::STAT_ILLEGAL |-> !m_tdata[3] && !m_tdata[2])
		else $error("illegal argument result carries a transmission or report");

	a_report_needs_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == ctbs_pkg::STAT_OVERFLOW)
		else $error("overflow report without overflow status");

	a_one_item_in_flight : assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while one is in work");

endmodule

@@ rtl/ctbs_mark_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbs_mark_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ctbs_mark_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 2
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/ctbs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbs_ctrl
// Sequencer that reads, modifies and writes back the buffer marks and keeps
// the pending counter, inhibit and boot state.
// ----------------------------------------------------------------------------
module ctbs_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  ctbs_pkg::ctbs_item_t         item,
	input  logic [ctbs_pkg::CNT_W-1:0]   count_in_use,
	output logic                         res_valid,
	input  logic                         res_ready,
	output ctbs_pkg::ctbs_result_t       res,
	output ctbs_pkg::ctbs_mem_req_t      mem_req,
	input  ctbs_pkg::ctbs_mark_t         mem_rdata
);

	ctbs_pkg::ctbs_state_t               state_q, state_d;
	ctbs_pkg::ctbs_item_t                item_q;
	logic [ctbs_pkg::CNT_W-1:0]          n_q;
	logic [ctbs_pkg::PEND_W-1:0]         pend_q, pend_d;
	logic                                inh_q, inh_d;
	logic                                boot_q, boot_d;
	ctbs_pkg::ctbs_result_t              res_q, res_d;
	logic [ctbs_pkg::CNT_W-1:0]          issue_q, issue_d;
	logic [ctbs_pkg::TX_BUFFERS-1:0]     vld_q;
	logic                                rd_pend_s1;
	logic [ctbs_pkg::IDX_W-1:0]          rd_idx_s1;
	logic                                rvld_s1;
	ctbs_pkg::ctbs_mark_t                mark_rd;
	logic                                idx_ok;
	logic                                last_rd;

	assign mark_rd = mem_rdata & {rvld_s1, rvld_s1};
	assign idx_ok  = 32'(item_q.buffer_index) < 32'(n_q);
	assign last_rd = (32'(rd_idx_s1) + 32'd1) == 32'(n_q);
	assign res     = res_q;

	always_comb begin
		state_d    = state_q;
		pend_d     = pend_q;
		inh_d      = inh_q;
		boot_d     = boot_q;
		res_d      = res_q;
		issue_d    = issue_q;
		mem_req    = '0;
		item_ready = 1'b0;
		res_valid  = 1'b0;
		unique case (state_q)
			ctbs_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = ctbs_pkg::S_EXEC;
				end
			end
			ctbs_pkg::S_EXEC: begin
				res_d = '0;
				unique case (item_q.operation)
					ctbs_pkg::OP_INIT: begin
						if (!idx_ok) begin
							res_d.status = ctbs_pkg::STAT_ILLEGAL;
						end else begin
							mem_req.we         = 1'b1;
							mem_req.waddr      = ctbs_pkg::IDX_W'(item_q.buffer_index);
							mem_req.wdata.sync = item_q.sync_flag;
							mem_req.wdata.full = 1'b0;
						end
						state_d = ctbs_pkg::S_FINISH;
					end
					ctbs_pkg::OP_SEND: begin
						if (!idx_ok) begin
							res_d.status = ctbs_pkg::STAT_ILLEGAL;
							state_d      = ctbs_pkg::S_FINISH;
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = ctbs_pkg::IDX_W'(item_q.buffer_index);
							state_d       = ctbs_pkg::S_SEND;
						end
					end
					ctbs_pkg::OP_TX_DONE: begin
						boot_d = 1'b0;
						inh_d  = 1'b0;
						if (pend_q == '0) begin
							state_d = ctbs_pkg::S_FINISH;
						end else if (n_q == '0) begin
							pend_d  = '0;
							state_d = ctbs_pkg::S_FINISH;
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = '0;
							issue_d       = ctbs_pkg::CNT_W'(1);
							state_d       = ctbs_pkg::S_SCAN;
						end
					end
					default: begin
						if (inh_q) begin
							inh_d              = 1'b0;
							res_d.sync_dropped = ctbs_pkg::DROP_INHIBIT;
						end
						if (pend_q != '0 && n_q != '0) begin
							mem_req.re    = 1'b1;
							mem_req.raddr = '0;
							issue_d       = ctbs_pkg::CNT_W'(1);
							state_d       = ctbs_pkg::S_SCAN;
						end else begin
							state_d = ctbs_pkg::S_FINISH;
						end
					end
				endcase
			end
			ctbs_pkg::S_SEND: begin
				if (mark_rd.full) begin
					res_d.status          = ctbs_pkg::STAT_OVERFLOW;
					res_d.overflow_report = !boot_q;
				end
				if (item_q.mailbox_free && pend_q == '0) begin
					inh_d                = mark_rd.sync;
					res_d.transmit_valid = 1'b1;
					res_d.transmit_index = item_q.buffer_index;
				end else begin
					mem_req.we         = 1'b1;
					mem_req.waddr      = ctbs_pkg::IDX_W'(item_q.buffer_index);
					mem_req.wdata.sync = mark_rd.sync;
					mem_req.wdata.full = 1'b1;
					if (pend_q != ctbs_pkg::PEND_MAX) begin
						pend_d = pend_q + 1'b1;
					end
				end
				state_d = ctbs_pkg::S_FINISH;
			end
			ctbs_pkg::S_SCAN: begin
				if (issue_q < n_q) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = ctbs_pkg::IDX_W'(issue_q);
					issue_d       = issue_q + 1'b1;
				end
				if (rd_pend_s1) begin
					if (item_q.operation == ctbs_pkg::OP_TX_DONE) begin
						if (mark_rd.full) begin
							mem_req.we           = 1'b1;
							mem_req.waddr        = rd_idx_s1;
							mem_req.wdata.sync   = mark_rd.sync;
							mem_req.wdata.full   = 1'b0;
							pend_d               = pend_q - 1'b1;
							inh_d                = mark_rd.sync;
							res_d.transmit_valid = 1'b1;
							res_d.transmit_index = ctbs_pkg::BUF_INDEX_W'(rd_idx_s1);
							state_d              = ctbs_pkg::S_FINISH;
						end else if (last_rd) begin
							pend_d  = '0;
							state_d = ctbs_pkg::S_FINISH;
						end
					end else begin
						if (mark_rd.full && mark_rd.sync) begin
							mem_req.we         = 1'b1;
							mem_req.waddr      = rd_idx_s1;
							mem_req.wdata.sync = 1'b1;
							mem_req.wdata.full = 1'b0;
							if (pend_q != '0) begin
								pend_d = pend_q - 1'b1;
							end
							res_d.sync_dropped = ctbs_pkg::DROP_QUEUED;
						end
						if (last_rd) begin
							state_d = ctbs_pkg::S_FINISH;
						end
					end
				end
			end
			ctbs_pkg::S_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ctbs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ctbs_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ctbs_pkg::S_IDLE;
			pend_q     <= '0;
			inh_q      <= 1'b0;
			boot_q     <= 1'b1;
			vld_q      <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			pend_q     <= pend_d;
			inh_q      <= inh_d;
			boot_q     <= boot_d;
			rd_pend_s1 <= mem_req.re;
			if (mem_req.we) begin
				vld_q[mem_req.waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
			n_q    <= count_in_use;
		end
		res_q     <= res_d;
		issue_q   <= issue_d;
		rd_idx_s1 <= mem_req.raddr;
		rvld_s1   <= vld_q[mem_req.raddr];
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CAN transmit buffer scheduler. A scoreboard
// keeps its own copy of the buffer marks, pending counter, inhibit and boot
// state, predicts one result per accepted transaction and compares every
// returned transaction field by field. Directed tests cover the corner
// cases, then random traffic runs under several buffer counts with bursty
// input and a stalling output.
// ----------------------------------------------------------------------------
module tb_top;
	import ctbs_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 4000000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned REPEAT_SENDS = 40;
	localparam logic [APB_ADDR_W-1:0] REG_BUFFERS_IN_USE = APB_ADDR_W'(0);

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// buffer_index, sync_flag, mailbox_free, zero pad
	logic [7:0]            s_tdata;
	// operation
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// status, overflow_report, transmit_valid, transmit_index, sync_dropped, zero pad
	logic [15:0]           m_tdata;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	// Shadow of the scheduler state.
	logic [TX_BUFFERS-1:0] full_mark = '0;
	logic [TX_BUFFERS-1:0] sync_mark = '0;
	logic [PEND_W-1:0]     pend_count = '0;
	logic                  inhibit_now = 1'b0;
	logic                  boot_open = 1'b1;
	logic [CFG_W-1:0]      buf_count = BUFFERS_IN_USE_RST;

	ctbs_result_t awaited_outcomes[$];
	int unsigned  error_count = 0;
	int unsigned  cycle_count = 0;
	int unsigned  burst_left = 0;
	logic         no_idle = 1'b0;
	logic         no_stall = 1'b0;
	logic [7:0]   stall_pattern = 8'hFF;
	logic [5:0]   stall_phase = '0;

	can_tx_buffer_scheduler u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		error_count++;
		if (error_count <= 40)
			$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic ctbs_result_t predict_schedule(input ctbs_item_t it);
		ctbs_result_t r;
		int unsigned  n;
		int unsigned  i;
		logic         found;
		r = '0;
		found = 1'b0;
		n = (buf_count > TX_BUFFERS) ? TX_BUFFERS : buf_count;
		case (it.operation)
			OP_INIT: begin
				if (it.buffer_index >= n) begin
					r.status = STAT_ILLEGAL;
				end else begin
					sync_mark[it.buffer_index] = it.sync_flag;
					full_mark[it.buffer_index] = 1'b0;
				end
			end
			OP_SEND: begin
				if (it.buffer_index >= n) begin
					r.status = STAT_ILLEGAL;
				end else begin
					if (full_mark[it.buffer_index]) begin
						r.status = STAT_OVERFLOW;
						r.overflow_report = !boot_open;
					end
					if (it.mailbox_free && pend_count == '0) begin
						inhibit_now = sync_mark[it.buffer_index];
						r.transmit_valid = 1'b1;
						r.transmit_index = it.buffer_index;
					end else begin
						full_mark[it.buffer_index] = 1'b1;
						if (pend_count != PEND_MAX)
							pend_count++;
					end
				end
			end
			OP_TX_DONE: begin
				boot_open = 1'b0;
				inhibit_now = 1'b0;
				if (pend_count != '0) begin
					for (i = 0; i < n && !found; i++) begin
						if (full_mark[i]) begin
							full_mark[i] = 1'b0;
							pend_count--;
							inhibit_now = sync_mark[i];
							r.transmit_valid = 1'b1;
							r.transmit_index = BUF_INDEX_W'(i);
							found = 1'b1;
						end
					end
					if (!found)
						pend_count = '0;
				end
			end
			default: begin
				if (inhibit_now) begin
					inhibit_now = 1'b0;
					r.sync_dropped = DROP_INHIBIT;
				end
				if (pend_count != '0) begin
					for (i = 0; i < n; i++) begin
						if (full_mark[i] && sync_mark[i]) begin
							full_mark[i] = 1'b0;
							if (pend_count != '0)
								pend_count--;
							r.sync_dropped = DROP_QUEUED;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	// Results are checked before the new input transaction of the same edge is
	// predicted, so the queue order never depends on process scheduling.
	always @(posedge clk) begin : scoreboard
		ctbs_result_t got;
		ctbs_result_t want;
		ctbs_item_t   taken;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_outcomes.size() == 0) begin
				report_mismatch("unexpected result transaction", 1, 0);
			end else begin
				want = awaited_outcomes.pop_front();
				got = m_tdata[10:0];
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.overflow_report !== want.overflow_report)
					report_mismatch("overflow_report", got.overflow_report,
						want.overflow_report);
				if (got.transmit_valid !== want.transmit_valid)
					report_mismatch("transmit_valid", got.transmit_valid,
						want.transmit_valid);
				if (got.transmit_index !== want.transmit_index)
					report_mismatch("transmit_index", got.transmit_index,
						want.transmit_index);
				if (got.sync_dropped !== want.sync_dropped)
					report_mismatch("sync_dropped", got.sync_dropped, want.sync_dropped);
				if (m_tdata[15:11] !== '0)
					report_mismatch("tdata pad bits", m_tdata[15:11], 0);
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			taken.operation = ctbs_op_t'(s_tuser);
			taken.buffer_index = s_tdata[4:0];
			taken.sync_flag = s_tdata[5];
			taken.mailbox_free = s_tdata[6];
			awaited_outcomes.push_back(predict_schedule(taken));
		end
	end

	always @(posedge clk) begin
		stall_phase <= stall_phase + 6'd1;
		if (stall_phase == '0)
			stall_pattern <= 8'($urandom);
		m_tready <= no_stall || stall_pattern[stall_phase[2:0]];
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_item(input ctbs_item_t it);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, it.mailbox_free, it.sync_flag, it.buffer_index};
		s_tuser <= it.operation;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (!no_idle) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_buffers_in_use(input logic [CFG_W-1:0] value);
		logic [31:0] readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_BUFFERS_IN_USE;
		pwdata <= {26'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		buf_count = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== {26'd0, value})
			report_mismatch("buffers_in_use readback", readback, value);
	endtask

	function automatic ctbs_item_t random_item();
		ctbs_item_t  it;
		int unsigned n;
		int unsigned pick;
		n = (buf_count > TX_BUFFERS) ? TX_BUFFERS : buf_count;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			it.operation = OP_INIT;
		else if (pick < 58)
			it.operation = OP_SEND;
		else if (pick < 85)
			it.operation = OP_TX_DONE;
		else
			it.operation = OP_CLR_SYNC;
		pick = $urandom_range(0, 9);
		if (n == 0 || pick == 0)
			it.buffer_index = BUF_INDEX_W'($urandom);
		else if (pick < 4)
			it.buffer_index = BUF_INDEX_W'($urandom_range(0, (n > 4) ? 3 : n - 1));
		else
			it.buffer_index = BUF_INDEX_W'($urandom_range(0, n - 1));
		it.sync_flag = 1'($urandom);
		it.mailbox_free = ($urandom_range(0, 2) != 0);
		return it;
	endfunction

	// Runs right after reset, while the boot frame is still outstanding.
	task automatic test_directed();
		send_item('{OP_SEND, 5'd0, 1'b0, 1'b0});
		send_item('{OP_SEND, 5'd0, 1'b0, 1'b0});
		send_item('{OP_SEND, 5'd31, 1'b1, 1'b1});
		send_item('{OP_INIT, 5'd0, 1'b1, 1'b0});
		send_item('{OP_TX_DONE, 5'd31, 1'b1, 1'b1});
		send_item('{OP_TX_DONE, 5'd0, 1'b0, 1'b0});
		send_item('{OP_SEND, 5'd5, 1'b0, 1'b1});
		send_item('{OP_INIT, 5'd3, 1'b1, 1'b1});
		send_item('{OP_SEND, 5'd3, 1'b0, 1'b1});
		send_item('{OP_CLR_SYNC, 5'd31, 1'b1, 1'b1});
		send_item('{OP_SEND, 5'd3, 1'b0, 1'b0});
		send_item('{OP_SEND, 5'd3, 1'b1, 1'b0});
		send_item('{OP_TX_DONE, 5'd0, 1'b0, 1'b0});
		send_item('{OP_SEND, 5'd3, 1'b0, 1'b0});
		send_item('{OP_CLR_SYNC, 5'd0, 1'b0, 1'b0});
		send_item('{OP_CLR_SYNC, 5'd0, 1'b0, 1'b0});
		send_item('{OP_TX_DONE, 5'd0, 1'b0, 1'b0});
		drain();
	endtask

	task automatic test_buffer_count();
		write_buffers_in_use(6'd0);
		send_item('{OP_INIT, 5'd0, 1'b1, 1'b0});
		send_item('{OP_SEND, 5'd0, 1'b0, 1'b1});
		send_item('{OP_TX_DONE, 5'd0, 1'b0, 1'b0});
		send_item('{OP_CLR_SYNC, 5'd0, 1'b0, 1'b0});
		drain();
		write_buffers_in_use(6'd1);
		send_item('{OP_INIT, 5'd1, 1'b0, 1'b0});
		send_item('{OP_SEND, 5'd0, 1'b0, 1'b1});
		send_item('{OP_SEND, 5'd1, 1'b0, 1'b1});
		send_item('{OP_SEND, 5'd0, 1'b0, 1'b0});
		drain();
		write_buffers_in_use(6'd63);
		send_item('{OP_SEND, 5'd31, 1'b0, 1'b0});
		send_item('{OP_TX_DONE, 5'd0, 1'b0, 1'b0});
		send_item('{OP_TX_DONE, 5'd0, 1'b0, 1'b0});
		drain();
	endtask

	// Queues the same buffer many times so the pending counter runs ahead of
	// the full marks, then checks that a scan that finds nothing zeroes it.
	task automatic test_pending_overcount();
		int unsigned k;
		write_buffers_in_use(6'd32);
		no_idle = 1'b1;
		no_stall = 1'b1;
		for (k = 0; k < TX_BUFFERS; k++)
			send_item('{OP_INIT, BUF_INDEX_W'(k), 1'b0, 1'b0});
		send_item('{OP_TX_DONE, 5'd0, 1'b0, 1'b0});
		send_item('{OP_SEND, 5'd7, 1'b0, 1'b0});
		for (k = 0; k < REPEAT_SENDS; k++)
			send_item('{OP_SEND, 5'd7, 1'b0, 1'($urandom)});
		send_item('{OP_SEND, 5'd8, 1'b0, 1'b1});
		send_item('{OP_TX_DONE, 5'd0, 1'b0, 1'b0});
		send_item('{OP_TX_DONE, 5'd0, 1'b0, 1'b0});
		send_item('{OP_TX_DONE, 5'd0, 1'b0, 1'b0});
		send_item('{OP_SEND, 5'd9, 1'b0, 1'b1});
		drain();
		no_idle = 1'b0;
		no_stall = 1'b0;
	endtask

	task automatic test_random();
		logic [CFG_W-1:0] counts [8];
		int unsigned      ph;
		int unsigned      k;
		counts = '{6'd32, 6'd63, 6'd1, 6'd0, 6'd33, 6'd2, 6'd17, 6'd5};
		counts[7] = CFG_W'($urandom_range(0, 63));
		for (ph = 0; ph < 8; ph++) begin
			drain();
			write_buffers_in_use(counts[ph]);
			no_idle = (ph % 4 == 3);
			no_stall = (ph % 4 == 1);
			for (k = 0; k < 225; k++) begin
				if ($urandom_range(0, 149) == 0)
					drain();
				send_item(random_item());
			end
		end
		no_idle = 1'b0;
		no_stall = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_buffer_count();
		test_pending_overcount();
		test_random();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
